FILE: design/spq_pkg.sv
package spq_pkg;

    // Queue geometry.
    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    // Field widths.
    localparam int KEY_W = 16;
    localparam int TAG_W = 16;
    localparam int OCC_W = 5;
    localparam int ST_W  = 2;
    localparam int ENT_W = KEY_W + TAG_W;

    // Request kinds.
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // Result status codes.
    localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
    localparam logic [ST_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [ST_W-1:0] STAT_EMPTY = 2'd2;

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] count_t;

    // One result beat as it travels from the sequencer to the output queue.
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    // Physical slot of the logical position off, counted from the head of the ring.
    function automatic addr_t ring_add(addr_t head, addr_t off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (AW + 1)'(DEPTH)) begin
            sum = sum - (AW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Occupancy is reported in its low bits.
    function automatic logic [OCC_W-1:0] to_occ(count_t cnt);
        return OCC_W'(cnt);
    endfunction

endpackage

FILE: design/spq_ram.sv
module spq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4,
    parameter int WORDS  = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [WORDS];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/spq_ctrl.sv
module spq_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            req_type,
    input  logic [spq_pkg::KEY_W-1:0]       req_key,
    input  logic [spq_pkg::TAG_W-1:0]       req_tag,
    input  logic                            res_room,
    output logic                            res_valid,
    output spq_pkg::result_t                res_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_INS  = 2'd2;
    localparam logic [1:0] ST_DEQ  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    spq_pkg::addr_t                head_reg, head_next;
    spq_pkg::count_t               count_reg, count_next;
    spq_pkg::addr_t                cur_reg, cur_next;
    logic [spq_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [spq_pkg::TAG_W-1:0]     tag_reg, tag_next;

    logic                          wr_en;
    spq_pkg::addr_t                wr_addr;
    logic [spq_pkg::ENT_W-1:0]     wr_data;
    logic                          rd_en;
    spq_pkg::addr_t                rd_addr;
    logic [spq_pkg::ENT_W-1:0]     rd_data;
    logic [spq_pkg::KEY_W-1:0]     rd_key;
    logic [spq_pkg::TAG_W-1:0]     rd_tag;
    logic                          accept;

    // Entries are stored as {tag, key}, held in a ring that starts at the head.
    spq_ram #(
        .DATA_W (spq_pkg::ENT_W),
        .ADDR_W (spq_pkg::AW),
        .WORDS  (spq_pkg::DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key    = rd_data[spq_pkg::KEY_W-1:0];
    assign rd_tag    = rd_data[spq_pkg::ENT_W-1:spq_pkg::KEY_W];
    assign req_ready = (state_reg == ST_IDLE) && res_room;
    assign accept    = req_valid && req_ready;

    // Sequencer: an enqueue walks from the tail toward the head, moving every entry
    // whose key is not greater than the new key one slot back, then drops the new
    // entry into the gap. A dequeue reads the head and advances it.
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        wr_data    = {tag_reg, key_reg};
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        res_valid  = 1'b0;
        res_data   = '{status: spq_pkg::STAT_OK, key: '0, tag: '0,
                       occupancy: spq_pkg::to_occ(count_reg)};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_valid = 1'b1;
                    if (req_type == spq_pkg::REQ_ENQ) begin
                        if (count_reg == spq_pkg::CW'(spq_pkg::DEPTH)) begin
                            res_data.status = spq_pkg::STAT_FULL;
                        end else begin
                            count_next = count_reg + spq_pkg::CW'(1);
                            res_data.occupancy = spq_pkg::to_occ(count_next);
                            key_next = req_key;
                            tag_next = req_tag;
                            if (count_reg == '0) begin
                                // Empty queue: the new entry becomes the head.
                                wr_en   = 1'b1;
                                wr_addr = head_reg;
                                wr_data = {req_tag, req_key};
                            end else begin
                                cur_next   = spq_pkg::AW'(count_reg - spq_pkg::CW'(1));
                                rd_en      = 1'b1;
                                rd_addr    = spq_pkg::ring_add(head_reg, cur_next);
                                state_next = ST_SCAN;
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_data.status = spq_pkg::STAT_EMPTY;
                        end else begin
                            // The result leaves once the head entry has been read.
                            res_valid  = 1'b0;
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = ST_DEQ;
                        end
                    end
                end
            end
            ST_SCAN: begin
                wr_en   = 1'b1;
                wr_addr = spq_pkg::ring_add(head_reg, cur_reg + spq_pkg::AW'(1));
                if (rd_key <= key_reg) begin
                    // Move this entry back by one and look at the one ahead.
                    wr_data = rd_data;
                    if (cur_reg == '0) begin
                        state_next = ST_INS;
                    end else begin
                        cur_next = cur_reg - spq_pkg::AW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = spq_pkg::ring_add(head_reg, cur_next);
                    end
                end else begin
                    wr_data    = {tag_reg, key_reg};
                    state_next = ST_IDLE;
                end
            end
            ST_INS: begin
                // Every stored key was not greater: the new entry takes the head slot.
                wr_en      = 1'b1;
                wr_addr    = head_reg;
                wr_data    = {tag_reg, key_reg};
                state_next = ST_IDLE;
            end
            ST_DEQ: begin
                res_valid  = 1'b1;
                count_next = count_reg - spq_pkg::CW'(1);
                head_next  = spq_pkg::ring_add(head_reg, spq_pkg::AW'(1));
                res_data   = '{status: spq_pkg::STAT_OK, key: rd_key, tag: rd_tag,
                               occupancy: spq_pkg::to_occ(count_next)};
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state resets; the held request needs none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            cur_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

FILE: design/spq_outq.sv
module spq_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  spq_pkg::result_t  push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output spq_pkg::result_t  out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    spq_pkg::result_t  out_data_reg;
    spq_pkg::result_t  skid_data_reg;
    logic              pop;
    logic              load_out;
    logic              load_skid;

    assign pop       = out_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A pushed beat lands in the output register when it is free, or draining with the
    // skid slot empty; otherwise in the skid slot.
    assign load_out  = push && (!out_valid_reg || (pop && !skid_valid_reg));
    assign load_skid = push && !load_out;

    // Two-beat output queue: the output register and a skid slot behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (load_out) begin
            out_valid_next = 1'b1;
        end
        if (load_skid) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
        if (load_out) begin
            out_data_reg <= push_data;
        end
        if (load_skid) begin
            skid_data_reg <= push_data;
        end
    end

endmodule

FILE: design/sorted_priority_queue.sv
// Sorted priority queue of spq_pkg::DEPTH entries, largest key at the head.
// Request channel (s_): s_tuser carries the request kind (0 enqueue, 1 dequeue),
// s_tdata carries the key and tag. Every request beat gives one result beat.
// Result channel (m_): m_tuser carries the status (0 ok, 1 enqueue dropped because
// the queue is full, 2 dequeue on an empty queue), m_tdata the dequeued key and tag
// (zero otherwise) and the occupancy after the request.
// Entries live in a ring in one RAM with a registered read port; the head pointer
// makes a dequeue one read. A dequeue reads the head when its beat is taken and
// pushes its result once the read is done. An enqueue result is pushed when its
// beat is taken; the insert then walks the RAM from the tail, one entry a cycle,
// moving back the stored keys not greater than the new key, and the block takes no
// new request until it ends. An enqueue into an empty queue writes the head slot
// directly. A drop or an empty dequeue pushes its result when its beat is taken.
// Reset (aresetn low, synchronous) empties the queue and the result queue; the RAM
// itself is not cleared. A stalled receiver is absorbed by a two-beat result queue;
// s_tready drops while that queue holds two beats.
module sorted_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key [15:0], tag [31:16]
    input  logic [0:0]  s_tuser,   // req_type [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_key [15:0], out_tag [31:16], occupancy [36:32]
    output logic [1:0]  m_tuser    // status [1:0]
);

    logic              res_valid;
    logic              res_room;
    spq_pkg::result_t  res_data;
    spq_pkg::result_t  out_data;

    spq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_type  (s_tuser[0]),
        .req_key   (s_tdata[15:0]),
        .req_tag   (s_tdata[31:16]),
        .res_room  (res_room),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    spq_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res_data),
        .room      (res_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    // Pack the result beat.
    assign m_tdata = {3'b000, out_data.occupancy, out_data.tag, out_data.key};
    assign m_tuser = out_data.status;

endmodule

FILE: dv/spq_checker.sv
// Watches both channels of the sorted priority queue, keeps a mirror of its
// store, and compares every result beat with the reply the mirror predicts.
module spq_reply_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // key [15:0], tag [31:16]
    input  logic [0:0]  s_tuser,   // req_type [0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // out_key [15:0], out_tag [31:16], occupancy [36:32]
    input  logic [1:0]  m_tuser,   // status [1:0]
    output int          error_count,
    output int          replies_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the queue contents, slot 0 is the head.
    logic [spq_pkg::KEY_W-1:0] mirror_keys [spq_pkg::DEPTH];
    logic [spq_pkg::TAG_W-1:0] mirror_tags [spq_pkg::DEPTH];
    int                        mirror_count;

    // Replies predicted for accepted requests, oldest first.
    spq_pkg::result_t          owed_replies [$];
    int                        errors;

    // Applies one request to the mirror and returns the reply it must produce.
    function automatic spq_pkg::result_t apply_request(logic req,
                                                       logic [spq_pkg::KEY_W-1:0] k,
                                                       logic [spq_pkg::TAG_W-1:0] t);
        spq_pkg::result_t r;
        int               pos;
        int               i;
        r = '0;
        if (req == spq_pkg::REQ_ENQ) begin
            if (mirror_count >= spq_pkg::DEPTH) begin
                r.status = spq_pkg::STAT_FULL;
            end else begin
                // The new entry goes behind every strictly larger key.
                pos = 0;
                while (pos < mirror_count && mirror_keys[pos] > k) begin
                    pos++;
                end
                for (i = mirror_count; i > pos; i--) begin
                    mirror_keys[i] = mirror_keys[i-1];
                    mirror_tags[i] = mirror_tags[i-1];
                end
                mirror_keys[pos] = k;
                mirror_tags[pos] = t;
                mirror_count++;
                r.status = spq_pkg::STAT_OK;
            end
        end else if (mirror_count == 0) begin
            r.status = spq_pkg::STAT_EMPTY;
        end else begin
            // Pop the head and close the gap.
            r.status = spq_pkg::STAT_OK;
            r.key    = mirror_keys[0];
            r.tag    = mirror_tags[0];
            for (i = 1; i < mirror_count; i++) begin
                mirror_keys[i-1] = mirror_keys[i];
                mirror_tags[i-1] = mirror_tags[i];
            end
            mirror_count--;
        end
        r.occupancy = spq_pkg::OCC_W'(mirror_count);
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Request beats feed the mirror; result beats are matched in order.
    always @(posedge aclk) begin : watch
        spq_pkg::result_t want;
        spq_pkg::result_t got;
        if (!aresetn) begin
            mirror_count = 0;
            owed_replies.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                owed_replies.push_back(apply_request(s_tuser[0], s_tdata[15:0],
                                                     s_tdata[31:16]));
            end
            if (m_tvalid && m_tready) begin
                got.status    = m_tuser;
                got.key       = m_tdata[15:0];
                got.tag       = m_tdata[31:16];
                got.occupancy = m_tdata[36:32];
                if (owed_replies.size() == 0) begin
                    $display("%0t: result beat with none expected: expected nothing, got %p",
                             $time, got);
                    errors++;
                end else begin
                    want = owed_replies.pop_front();
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("out_key", int'(want.key), int'(got.key));
                    check_field("out_tag", int'(want.tag), int'(got.tag));
                    check_field("occupancy", int'(want.occupancy), int'(got.occupancy));
                end
            end
        end
        error_count  <= errors;
        replies_owed <= owed_replies.size();
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {RDY_OPEN, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // key [15:0], tag [31:16]
    logic [0:0]  s_tuser  = '0;    // req_type [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // out_key [15:0], out_tag [31:16], occupancy [36:32]
    logic [1:0]  m_tuser;          // status [1:0]

    int          error_count;
    int          replies_owed;
    int          cycles = 0;

    ready_mode_t ready_mode = RDY_OPEN;
    int          mode_left  = 0;

    always #6 aclk = ~aclk;

    sorted_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    spq_reply_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .error_count  (error_count),
        .replies_owed (replies_owed)
    );

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The receiver switches between open, random, sparse and toggling stretches.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(8, 80);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RDY_OPEN:   m_tready <= 1'b1;
            RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:    m_tready <= ~m_tready;
        endcase
    end

    // Presents one request beat and holds it until it is taken.
    task automatic send_request(logic req, logic [spq_pkg::KEY_W-1:0] k,
                                logic [spq_pkg::TAG_W-1:0] t);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {t, k};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Holds the sender back until every predicted reply has arrived.
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_owed != 0);
    endtask

    // Keys lean toward the extremes and a narrow range so that ties are common.
    function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return spq_pkg::KEY_W'($urandom_range(0, 7));
            5:       return spq_pkg::KEY_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return spq_pkg::KEY_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int burst;
        int phase_left;
        int enq_pct;
        logic req;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty dequeue, key extremes, equal keys, drain past empty.
        send_request(spq_pkg::REQ_DEQ, 16'hFFFF, 16'hFFFF);
        send_request(spq_pkg::REQ_ENQ, 16'h0000, 16'h0000);
        send_request(spq_pkg::REQ_ENQ, 16'hFFFF, 16'hFFFF);
        send_request(spq_pkg::REQ_ENQ, 16'h8000, 16'h1111);
        send_request(spq_pkg::REQ_ENQ, 16'h8000, 16'h2222);
        send_request(spq_pkg::REQ_ENQ, 16'h8000, 16'h3333);
        send_request(spq_pkg::REQ_ENQ, 16'h0000, 16'hA5A5);
        repeat (8) send_request(spq_pkg::REQ_DEQ, 16'h5A5A, 16'hC3C3);
        wait_for_replies();

        // Random phases: fill-heavy, drain-heavy or mixed, sent in bursts.
        sent       = 0;
        phase_left = 0;
        enq_pct    = 50;
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    wait_for_replies();
                end
                phase_left = $urandom_range(10, 60);
                case ($urandom_range(0, 3))
                    0:       enq_pct = 90;
                    1:       enq_pct = 15;
                    2:       enq_pct = 100;
                    default: enq_pct = 50;
                endcase
            end
            burst = $urandom_range(1, 16);
            while (burst > 0 && phase_left > 0) begin
                req = ($urandom_range(1, 100) <= enq_pct) ? spq_pkg::REQ_ENQ
                                                          : spq_pkg::REQ_DEQ;
                send_request(req, pick_key(), spq_pkg::TAG_W'($urandom));
                sent++;
                burst--;
                phase_left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                idle_sender($urandom_range(1, 6));
            end
        end

        // Let the last replies arrive and the block settle.
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && replies_owed == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
